/* rtl/core/vtr_pkg.sv */
// Shared types, constants and sine table for the vertex translate-rotate block.
package vtr_pkg;

    // Trig values are Q12 with a range of -4096 to 4096.
    localparam int TRIG_BITS = 12;
    localparam int TRIG_W    = 14;
    localparam int OUT_BITS  = 51;
    localparam int ANG_W     = 9;
    localparam int SHIFT_W   = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 14'sd4096;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // Sine and cosine of one rotation angle.
    typedef struct packed {
        trig_t s;
        trig_t c;
    } rot_coef_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_ROT_X   = 3'd1,
        CFG_ROT_Y   = 3'd2,
        CFG_ROT_Z   = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5,
        CFG_SHIFT_Z = 3'd6
    } cfg_index_t;

    // Q12 sine of 0 to 90 degrees, rounded half away from zero.
    localparam logic [12:0] SIN_TAB [0:90] = '{
        13'd0,    13'd71,   13'd143,  13'd214,  13'd286,  13'd357,  13'd428,
        13'd499,  13'd570,  13'd641,  13'd711,  13'd782,  13'd852,  13'd921,
        13'd991,  13'd1060, 13'd1129, 13'd1198, 13'd1266, 13'd1334, 13'd1401,
        13'd1468, 13'd1534, 13'd1600, 13'd1666, 13'd1731, 13'd1796, 13'd1860,
        13'd1923, 13'd1986, 13'd2048, 13'd2110, 13'd2171, 13'd2231, 13'd2290,
        13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578, 13'd2633, 13'd2687,
        13'd2741, 13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996, 13'd3044,
        13'd3091, 13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355,
        13'd3396, 13'd3435, 13'd3474, 13'd3511, 13'd3547, 13'd3582, 13'd3617,
        13'd3650, 13'd3681, 13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824,
        13'd3849, 13'd3873, 13'd3896, 13'd3917, 13'd3937, 13'd3956, 13'd3974,
        13'd3991, 13'd4006, 13'd4021, 13'd4034, 13'd4046, 13'd4056, 13'd4065,
        13'd4074, 13'd4080, 13'd4086, 13'd4090, 13'd4094, 13'd4095, 13'd4096
    };

    // Map a signed angle register onto 0 to 359 degrees.
    function automatic logic [8:0] ang_norm(input logic signed [ANG_W-1:0] ang);
        logic signed [9:0] t;
        t = 10'(ang);
        if (t < 0)
        begin
            t = t + 10'sd360;
        end
        return t[8:0];
    endfunction

    // Q12 sine of an angle of 0 to 359 degrees, folded onto the quarter table.
    function automatic trig_t q12_sin(input logic [8:0] d);
        logic [8:0] idx;
        logic       neg;
        trig_t      mag;
        neg = 1'b0;
        if (d <= 9'd90)
        begin
            idx = d;
        end
        else if (d <= 9'd180)
        begin
            idx = 9'd180 - d;
        end
        else if (d <= 9'd270)
        begin
            idx = d - 9'd180;
            neg = 1'b1;
        end
        else
        begin
            idx = 9'd360 - d;
            neg = 1'b1;
        end
        mag = {1'b0, SIN_TAB[idx[6:0]]};
        return neg ? -mag : mag;
    endfunction

    // Sine and cosine of a signed angle register.
    function automatic rot_coef_t coef_of(input logic signed [ANG_W-1:0] ang);
        logic [8:0] d;
        logic [9:0] u;
        rot_coef_t  r;
        d = ang_norm(ang);
        u = {1'b0, d} + 10'd90;
        if (u >= 10'd360)
        begin
            u = u - 10'd360;
        end
        r.s = q12_sin(d);
        r.c = q12_sin(u[8:0]);
        return r;
    endfunction

endpackage

/* rtl/core/vtr_in_if.sv */
// Input vertex channel: valid, ready and the x, y, z coordinates.
interface vtr_in_if #(
    parameter int COORD_BITS = 48
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

/* rtl/core/vtr_out_if.sv */
// Output vertex channel: valid, ready and the transformed coordinates.
interface vtr_out_if import vtr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] x_out;
    logic signed [OUT_BITS-1:0] y_out;
    logic signed [OUT_BITS-1:0] z_out;

    modport source (output valid, output x_out, output y_out, output z_out, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

/* rtl/core/vertex_translate_rotate.sv */
// Top level of the vertex translate-rotate pipeline with its configuration registers.
//
// Takes one vertex per clock and returns one transformed vertex per clock; each
// passes a translation stage, then a multiply stage and an add-and-shift stage
// for each of the three plane rotations. The whole pipeline advances only when
// the output register is empty or its item is taken, so a stall on the output
// holds every stage in place. Sine and cosine of the configured angles are looked
// up and registered in the cycle after a write, which is still in time for the
// first rotation stage, so an item accepted in any cycle after the last
// configuration write sees the new settings. With enable clear the vertex passes
// through unchanged, sign-extended to the output width.
module vertex_translate_rotate import vtr_pkg::*; #(
    parameter int COORD_BITS = 48,
    parameter int FRAC_BITS  = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    vtr_in_if.sink               vtx_in,
    vtr_out_if.source            vtx_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Internal width holds any rotated vector of translated inputs.
    localparam int VW = COORD_BITS + 3;

    logic                      enable_reg;
    logic signed [ANG_W-1:0]   rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    rot_coef_t                 coef_x_reg, coef_y_reg, coef_z_reg;
    rot_coef_t                 coef_x_next, coef_y_next, coef_z_next;

    logic                      adv;
    logic signed [VW-1:0]      sx_ext, sy_ext, sz_ext;
    logic signed [VW-1:0]      x_t_next, y_t_next, z_t_next;
    logic signed [VW-1:0]      x_t_reg, y_t_reg, z_t_reg;
    logic                      v_t_reg;

    logic                      v_rx, v_ry, v_rz;
    logic signed [VW-1:0]      x_rx, y_rx, z_rx;
    logic signed [VW-1:0]      x_ry, y_ry, z_ry;
    logic signed [VW-1:0]      x_rz, y_rz, z_rz;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            rot_x_reg   <= '0;
            rot_y_reg   <= '0;
            rot_z_reg   <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_ROT_X:   rot_x_reg   <= cfg_data[ANG_W-1:0];
                CFG_ROT_Y:   rot_y_reg   <= cfg_data[ANG_W-1:0];
                CFG_ROT_Z:   rot_z_reg   <= cfg_data[ANG_W-1:0];
                CFG_SHIFT_X: shift_x_reg <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y: shift_y_reg <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Z: shift_z_reg <= cfg_data[SHIFT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Rotation coefficients; the identity rotation when the transform is off.
    always_comb
    begin
        if (enable_reg)
        begin
            coef_x_next = coef_of(rot_x_reg);
            coef_y_next = coef_of(rot_y_reg);
            coef_z_next = coef_of(rot_z_reg);
        end
        else
        begin
            coef_x_next = '{s: '0, c: TRIG_ONE};
            coef_y_next = '{s: '0, c: TRIG_ONE};
            coef_z_next = '{s: '0, c: TRIG_ONE};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= '{s: '0, c: TRIG_ONE};
            coef_y_reg <= '{s: '0, c: TRIG_ONE};
            coef_z_reg <= '{s: '0, c: TRIG_ONE};
        end
        else
        begin
            coef_x_reg <= coef_x_next;
            coef_y_reg <= coef_y_next;
            coef_z_reg <= coef_z_next;
        end
    end

    // Pipeline moves when the output register is free or being emptied.
    assign adv          = !v_rz || vtx_out.ready;
    assign vtx_in.ready = adv;

    // Translation stage.
    assign sx_ext   = enable_reg ? (VW'(shift_x_reg) <<< FRAC_BITS) : '0;
    assign sy_ext   = enable_reg ? (VW'(shift_y_reg) <<< FRAC_BITS) : '0;
    assign sz_ext   = enable_reg ? (VW'(shift_z_reg) <<< FRAC_BITS) : '0;
    assign x_t_next = VW'(vtx_in.x_in) + sx_ext;
    assign y_t_next = VW'(vtx_in.y_in) - sy_ext;
    assign z_t_next = VW'(vtx_in.z_in) - sz_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_t_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_t_reg <= vtx_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_t_reg <= x_t_next;
            y_t_reg <= y_t_next;
            z_t_reg <= z_t_next;
        end
    end

    // Rotate the (y,z) pair about the x axis.
    vtr_rot #(.VW(VW)) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_t_reg),
        .coef      (coef_x_reg),
        .a_in      (y_t_reg),
        .b_in      (z_t_reg),
        .p_in      (x_t_reg),
        .out_valid (v_rx),
        .a_out     (y_rx),
        .b_out     (z_rx),
        .p_out     (x_rx)
    );

    // Rotate the (x,z) pair about the y axis.
    vtr_rot #(.VW(VW)) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_rx),
        .coef      (coef_y_reg),
        .a_in      (x_rx),
        .b_in      (z_rx),
        .p_in      (y_rx),
        .out_valid (v_ry),
        .a_out     (x_ry),
        .b_out     (z_ry),
        .p_out     (y_ry)
    );

    // Rotate the (x,y) pair about the z axis; its last stage is the output register.
    vtr_rot #(.VW(VW)) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_ry),
        .coef      (coef_z_reg),
        .a_in      (x_ry),
        .b_in      (y_ry),
        .p_in      (z_ry),
        .out_valid (v_rz),
        .a_out     (x_rz),
        .b_out     (y_rz),
        .p_out     (z_rz)
    );

    assign vtx_out.valid = v_rz;
    assign vtx_out.x_out = OUT_BITS'(x_rz);
    assign vtx_out.y_out = OUT_BITS'(y_rz);
    assign vtx_out.z_out = OUT_BITS'(z_rz);

`ifndef SYNTHESIS
    // With the transform off the x-axis coefficients become the identity rotation.
    a_identity_off: assert property (@(posedge clk) disable iff (!rst_n)
        !enable_reg |=> (coef_x_reg.s == '0 && coef_x_reg.c == TRIG_ONE))
        else $error("coefficients are not the identity while disabled");

    // The z-axis sine and cosine stay within the Q12 unit range.
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        (coef_z_reg.c <= TRIG_ONE && coef_z_reg.c >= -TRIG_ONE &&
         coef_z_reg.s <= TRIG_ONE && coef_z_reg.s >= -TRIG_ONE))
        else $error("rotation coefficient out of range");

    // An accepted item occupies the translation stage in the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (vtx_in.valid && vtx_in.ready) |=> v_t_reg)
        else $error("accepted item lost at the translation stage");

    // A stalled pipeline holds its first stage.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_t_reg))
        else $error("translation stage moved during a stall");
`endif

endmodule

/* rtl/core/vtr_rot.sv */
// Two-stage plane rotation: four products, then sums shifted down by the trig scale.
module vtr_rot import vtr_pkg::*; #(
    parameter int VW = 51
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  rot_coef_t            coef,
    input  logic signed [VW-1:0] a_in,
    input  logic signed [VW-1:0] b_in,
    input  logic signed [VW-1:0] p_in,
    output logic                 out_valid,
    output logic signed [VW-1:0] a_out,
    output logic signed [VW-1:0] b_out,
    output logic signed [VW-1:0] p_out
);

    localparam int PW = VW + TRIG_W;

    logic signed [PW-1:0] ca_next, sb_next, cb_next, sa_next;
    logic signed [PW-1:0] ca_reg, sb_reg, cb_reg, sa_reg;
    logic signed [VW-1:0] p1_reg;
    logic                 v1_reg;
    logic signed [PW:0]   suma, sumb;
    logic signed [VW-1:0] a_next, b_next;
    logic signed [VW-1:0] a_reg, b_reg, p2_reg;
    logic                 v2_reg;

    // Product stage.
    assign ca_next = coef.c * a_in;
    assign sb_next = coef.s * b_in;
    assign cb_next = coef.c * b_in;
    assign sa_next = coef.s * a_in;

    // Sum stage; the arithmetic shift rounds toward minus infinity.
    assign suma   = (PW + 1)'(ca_reg) + (PW + 1)'(sb_reg);
    assign sumb   = (PW + 1)'(cb_reg) - (PW + 1)'(sa_reg);
    assign a_next = VW'(suma >>> TRIG_BITS);
    assign b_next = VW'(sumb >>> TRIG_BITS);

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Data of both stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_reg <= ca_next;
            sb_reg <= sb_next;
            cb_reg <= cb_next;
            sa_reg <= sa_next;
            p1_reg <= p_in;
            a_reg  <= a_next;
            b_reg  <= b_next;
            p2_reg <= p1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign p_out     = p2_reg;

endmodule
